// ----- rtl/fcw_pkg.sv -----
// ----------------------------------------------------------------------------
// fcw_pkg : FAT12 chain sector walker shared definitions
// Constants, codes and command/status types shared by controller and datapath.
// ----------------------------------------------------------------------------
package fcw_pkg;

	localparam int FAT_BYTES        = 8192;
	localparam int FAT_AW           = $clog2(FAT_BYTES);
	localparam int BYTES_PER_SECTOR = 512;

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_NEXT  = 2'd2;
	localparam logic [1:0] ACT_RSVD  = 2'd3;

	localparam logic [2:0] ST_READ = 3'd0;
	localparam logic [2:0] ST_END  = 3'd1;
	localparam logic [2:0] ST_BAD  = 3'd2;
	localparam logic [2:0] ST_CYL  = 3'd3;
	localparam logic [2:0] ST_IDLE = 3'd4;

	localparam logic [2:0] REG_RESERVED = 3'd0;
	localparam logic [2:0] REG_HIDDEN   = 3'd1;
	localparam logic [2:0] REG_COPIES   = 3'd2;
	localparam logic [2:0] REG_FATSEC   = 3'd3;
	localparam logic [2:0] REG_ROOT     = 3'd4;
	localparam logic [2:0] REG_CLUSEC   = 3'd5;
	localparam logic [2:0] REG_TRACK    = 3'd6;
	localparam logic [2:0] REG_HEADS    = 3'd7;

	typedef struct packed {
		logic       fat_wr;     // write FAT byte
		logic       start;      // load walk registers
		logic       rd_lo;      // issue FAT low byte read
		logic       rd_hi;      // issue FAT high byte read, form LBA
		logic       lba_calc;   // check stage: chain status valid
		logic       div_start;  // start division
		logic       div_sel;    // 0: lba/track, 1: track/heads
		logic       advance;    // advance walk pointers
	} fcw_cmd_t;

	typedef struct packed {
		logic       active;
		logic       cur_end;
		logic       cur_bad;    // cluster < 2 or entry out of range
		logic       next_bad;
		logic       div_done;
		logic       cyl_big;
		logic       tail;
	} fcw_sts_t;

endpackage

// ----- rtl/fat12_chain_sector_walker.sv -----
// ----------------------------------------------------------------------------
// fat12_chain_sector_walker : FAT12 cluster chain to CHS sector reads
// A next beat while the walk is idle is answered at the next edge, an ended
// or bad chain after the FAT low read, FAT high read and check states. A
// sector read goes through the same states and then the serial divisions by
// track and head count. One item in flight; the input opens once the result
// register is empty or being drained. Reset clears walk state and loads the
// geometry registers with defaults; the FAT memory is undefined until written.
// ----------------------------------------------------------------------------
module fat12_chain_sector_walker
	import fcw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// action[1:0] fat_address[14:2] fat_byte[22:15] first_cluster[34:23]
	// file_size[66:35] dest_segment[82:67] dest_offset[98:83]
	input  logic [103:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[2:0] cylinder[12:3] head[20:13] sector[26:21] byte_count[36:27]
	// dest_address[56:37] cluster[68:57] last[69]
	output logic [71:0]  m_tdata
);

	fcw_cmd_t cmd;
	fcw_sts_t sts;
	logic [9:0]  cyl, bc;
	logic [7:0]  hd;
	logic [5:0]  sc;
	logic [19:0] da;
	logic [11:0] cl;

	fcw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.action(s_tdata[1:0]), .fat_address(s_tdata[14:2]), .sts(sts), .cmd(cmd),
		.d_cylinder(cyl), .d_head(hd), .d_sector(sc), .d_byte_count(bc),
		.d_dest(da), .d_cluster(cl), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	fcw_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_fat_address(s_tdata[14:2]),
		.in_fat_byte(s_tdata[22:15]), .in_first_cluster(s_tdata[34:23]),
		.in_file_size(s_tdata[66:35]), .in_dest_segment(s_tdata[82:67]),
		.in_dest_offset(s_tdata[98:83]), .cmd(cmd), .sts(sts),
		.cylinder(cyl), .head(hd), .sector(sc), .byte_count(bc),
		.dest_address(da), .cluster(cl)
	);

	a_ready_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready) else $error("input taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result dropped");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.advance, cmd.lba_calc})) else $error("cmd clash");

endmodule

// ----- rtl/fcw_div.sv -----
// ----------------------------------------------------------------------------
// fcw_div : restoring divider, 32 by 8 bits
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module fcw_div
	import fcw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [7:0]  divisor,
	output logic        done,
	output logic [31:0] quot,
	output logic [7:0]  rem
);

	logic [31:0] q_q;
	logic [8:0]  r_q;
	logic [7:0]  d_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [8:0]  trial;
	logic [8:0]  diff;

	assign trial = {r_q[7:0], q_q[31]};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!diff[8]) begin
				r_q <= diff;
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
	assign rem  = r_q[7:0];

endmodule

// ----- rtl/fcw_datapath.sv -----
// ----------------------------------------------------------------------------
// fcw_datapath : FAT store, walk registers and CHS arithmetic
// Holds the FAT memory, geometry registers and the walk registers.
// ----------------------------------------------------------------------------
module fcw_datapath
	import fcw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [12:0] in_fat_address,
	input  logic [7:0]  in_fat_byte,
	input  logic [11:0] in_first_cluster,
	input  logic [31:0] in_file_size,
	input  logic [15:0] in_dest_segment,
	input  logic [15:0] in_dest_offset,
	input  fcw_cmd_t    cmd,
	output fcw_sts_t    sts,
	output logic [9:0]  cylinder,
	output logic [7:0]  head,
	output logic [5:0]  sector,
	output logic [9:0]  byte_count,
	output logic [19:0] dest_address,
	output logic [11:0] cluster
);

	logic [15:0] reserved_q, hidden_q;
	logic [7:0]  copies_q, clusec_q, heads_q;
	logic [4:0]  fatsec_q;
	logic [12:0] root_q;
	logic [5:0]  track_q;

	logic [7:0]  fat_mem [FAT_BYTES];
	logic [7:0]  rd_q, lo_q;
	logic [FAT_AW-1:0] rd_addr;

	logic [11:0] cur_q;
	logic [7:0]  sic_q;
	logic [31:0] done_q, size_q;
	logic [19:0] dest_q;
	logic        active_q;

	logic [31:0] lba_q;
	logic [7:0]  sec_rem_q;
	logic [11:0] next;
	logic [13:0] off;
	logic [7:0]  cs, trk, hds;
	logic [31:0] remaining;

	logic        div_done;
	logic [31:0] div_quot;
	logic [7:0]  div_rem;

	assign cs  = (clusec_q == 8'd0) ? 8'd1 : clusec_q;
	assign trk = (track_q == 6'd0) ? 8'd1 : {2'b00, track_q};
	assign hds = (heads_q == 8'd0) ? 8'd1 : heads_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= 16'd1;
			hidden_q   <= 16'd0;
			copies_q   <= 8'd2;
			fatsec_q   <= 5'd9;
			root_q     <= 13'd224;
			clusec_q   <= 8'd1;
			track_q    <= 6'd18;
			heads_q    <= 8'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RESERVED: reserved_q <= cfg_data;
				REG_HIDDEN:   hidden_q   <= cfg_data;
				REG_COPIES:   copies_q   <= cfg_data[7:0];
				REG_FATSEC:   fatsec_q   <= cfg_data[4:0];
				REG_ROOT:     root_q     <= cfg_data[12:0];
				REG_CLUSEC:   clusec_q   <= cfg_data[7:0];
				REG_TRACK:    track_q    <= cfg_data[5:0];
				REG_HEADS:    heads_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// FAT offset of the current entry: cur*3/2
	assign off = ({2'b00, cur_q} + {1'b0, cur_q, 1'b0}) >> 1;
	assign rd_addr = cmd.rd_hi ? FAT_AW'(off + 14'd1) : FAT_AW'(off);

	always_ff @(posedge clk) begin
		if (cmd.fat_wr) fat_mem[in_fat_address[FAT_AW-1:0]] <= in_fat_byte;
		if (cmd.rd_lo || cmd.rd_hi) rd_q <= fat_mem[rd_addr];
		if (cmd.rd_hi) lo_q <= rd_q;
	end

	assign next = cur_q[0] ? {rd_q, lo_q[7:4]} : {rd_q[3:0], lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			sic_q    <= '0;
			done_q   <= '0;
			size_q   <= '0;
			dest_q   <= '0;
			active_q <= 1'b0;
		end else if (cmd.start) begin
			cur_q    <= in_first_cluster;
			size_q   <= in_file_size;
			sic_q    <= '0;
			done_q   <= '0;
			dest_q   <= {in_dest_segment, 4'h0} + {4'h0, in_dest_offset};
			active_q <= 1'b1;
		end else if (cmd.advance) begin
			if (sts.tail || sts.cyl_big) begin
				active_q <= 1'b0;
			end else begin
				done_q <= done_q + 32'(BYTES_PER_SECTOR);
				dest_q <= dest_q + 20'(BYTES_PER_SECTOR);
				if (sic_q + 8'd1 >= cs) begin
					sic_q <= '0;
					cur_q <= next;
				end else begin
					sic_q <= sic_q + 8'd1;
				end
			end
		end else if (sts.active && (sts.cur_end || sts.cur_bad || sts.next_bad)
			&& cmd.lba_calc) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_hi)
			lba_q <= 32'(reserved_q) + 32'(hidden_q) + 32'(copies_q) * 32'(fatsec_q)
				+ 32'(root_q[12:4]) + (32'(cur_q) - 32'd2) * 32'(cs) + 32'(sic_q);
		if (cmd.div_start && cmd.div_sel)
			sec_rem_q <= div_rem;
	end

	fcw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (cmd.div_sel ? div_quot : lba_q),
		.divisor  (cmd.div_sel ? hds : trk),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign remaining = size_q - done_q;

	assign sts.active   = active_q;
	assign sts.cur_end  = (cur_q[11:3] == 9'h1FF);
	assign sts.cur_bad  = (cur_q < 12'd2) || (32'(off) + 32'd1 >= 32'(FAT_BYTES));
	assign sts.next_bad = (next[11:3] == 9'h1FE);
	assign sts.div_done = div_done;
	assign sts.cyl_big  = (div_quot > 32'd1023);
	assign sts.tail     = (remaining <= 32'(BYTES_PER_SECTOR));

	assign cylinder     = div_quot[9:0];
	assign head         = div_rem;
	assign sector       = 6'(sec_rem_q + 8'd1);
	assign byte_count   = sts.tail ? remaining[9:0] : 10'(BYTES_PER_SECTOR);
	assign dest_address = dest_q;
	assign cluster      = cur_q;

endmodule

// ----- rtl/fcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// fcw_ctrl : walk sequencer
// Accepts beats, steps FAT read and both divisions, holds the result beat.
// ----------------------------------------------------------------------------
module fcw_ctrl
	import fcw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  action,
	input  logic [12:0] fat_address,
	input  fcw_sts_t    sts,
	output fcw_cmd_t    cmd,
	input  logic [9:0]  d_cylinder,
	input  logic [7:0]  d_head,
	input  logic [5:0]  d_sector,
	input  logic [9:0]  d_byte_count,
	input  logic [19:0] d_dest,
	input  logic [11:0] d_cluster,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RDLO = 7'b0000010,
		S_RDHI = 7'b0000100,
		S_CHK  = 7'b0001000,
		S_DIV1 = 7'b0010000,
		S_DIV2 = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q;
	logic   acc;
	logic [2:0]  st;
	logic [9:0]  cyl, bc;
	logic [7:0]  hd;
	logic [5:0]  sc;
	logic [19:0] da;
	logic [11:0] cl;
	logic        lst, load;

	assign s_tready = (state_q == S_IDLE) && (!m_tvalid || m_tready);
	assign acc = s_tvalid && s_tready;

	always_comb begin
		cmd = '0;
		cmd.fat_wr = acc && action == ACT_WRITE && 32'(fat_address) < FAT_BYTES;
		cmd.start  = acc && action == ACT_START;
		cmd.rd_lo  = state_q == S_RDLO;
		cmd.rd_hi  = state_q == S_RDHI;
		cmd.lba_calc  = state_q == S_CHK;
		cmd.div_start = (state_q == S_CHK) || (state_q == S_DIV1 && sts.div_done);
		cmd.div_sel   = state_q == S_DIV2 || (state_q == S_DIV1 && sts.div_done);
		cmd.advance   = state_q == S_DIV2 && sts.div_done;
	end

	always_comb begin
		load = 1'b0;
		st = ST_READ; cyl = '0; hd = '0; sc = '0; bc = '0; da = '0; cl = '0; lst = 1'b1;
		if (acc && action == ACT_NEXT && !sts.active) begin
			load = 1'b1; st = ST_IDLE;
		end else if (state_q == S_CHK && (sts.cur_end || sts.cur_bad || sts.next_bad)) begin
			load = 1'b1; cl = d_cluster;
			st = sts.cur_end ? ST_END : ST_BAD;
		end else if (state_q == S_DIV2 && sts.div_done) begin
			load = 1'b1; cl = d_cluster;
			if (sts.cyl_big) begin
				st = ST_CYL;
			end else begin
				cyl = d_cylinder; hd = d_head; sc = d_sector; bc = d_byte_count;
				da = d_dest; lst = sts.tail;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			if (load) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: if (acc && action == ACT_NEXT && sts.active) state_q <= S_RDLO;
				S_RDLO: state_q <= S_RDHI;
				S_RDHI: state_q <= S_CHK;
				S_CHK:  state_q <= (sts.cur_end || sts.cur_bad || sts.next_bad)
					? S_IDLE : S_DIV1;
				S_DIV1: if (sts.div_done) state_q <= S_DIV2;
				S_DIV2: if (sts.div_done) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) m_tdata <= {2'b00, lst, cl, da, bc, sc, hd, cyl, st};
	end

endmodule
